FILE: rtl/core/sha1_pkg.sv
// shared types, constants and round functions for the sha-1 hash engine
// used by sha1_core and sha1_hash_engine; no dependencies
`timescale 1ns / 1ps

package sha1_pkg;

    typedef logic [4:0][31:0]  t_chain;
    typedef logic [15:0][31:0] t_block;

    // initial chaining value, word 0 in the lowest slot
    localparam t_chain SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                  32'hEFCDAB89, 32'h67452301};

    localparam logic [31:0] SHA1_K0 = 32'h5A827999;
    localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;

    localparam logic [6:0] ROUND_LAST    = 7'd79;
    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [5:0] BLOCK_LAST    = 6'd63;
    localparam logic [6:0] PAD_LEN_POS   = 7'd56;
    localparam logic [6:0] PAD_BLOCK_END = 7'd64;
    localparam logic [2:0] WORD_LAST     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_COMP,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_ADD
    } t_core_state;

    typedef struct packed {
        logic start;
        logic reinit;
    } t_core_ctl;

    function automatic logic [31:0] sha1_f(input logic [6:0] round,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
        logic [31:0] f;
        if (round < 7'd20) begin
            f = d ^ (b & (c ^ d));
        end else if (round < 7'd40) begin
            f = b ^ c ^ d;
        end else if (round < 7'd60) begin
            f = (b & c) | (d & (b | c));
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic logic [31:0] sha1_k(input logic [6:0] round);
        logic [31:0] k;
        if (round < 7'd20) begin
            k = SHA1_K0;
        end else if (round < 7'd40) begin
            k = SHA1_K1;
        end else if (round < 7'd60) begin
            k = SHA1_K2;
        end else begin
            k = SHA1_K3;
        end
        return k;
    endfunction

endpackage

FILE: rtl/core/sha1_core.sv
// sha-1 compression unit: one round per cycle over a rolling 16-word schedule
// holds the chaining value; depends on sha1_pkg
`timescale 1ns / 1ps

module sha1_core import sha1_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_core_ctl i_ctl,
    input  t_block    i_block,
    output t_chain    o_digest,
    output logic      o_done
);

    t_core_state r_state, n_state;
    t_chain      r_h;
    t_block      r_w;
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [6:0]  r_round;

    logic [31:0] w_sched_x;
    logic [31:0] w_sched_new;
    logic [31:0] w_t;

    // window holds w[t..t+15]; the next word is formed from the same window
    assign w_sched_x   = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_sched_new = {w_sched_x[30:0], w_sched_x[31]};
    assign w_t = {r_a[26:0], r_a[31:27]} + sha1_f(r_round, r_b, r_c, r_d)
               + r_e + sha1_k(r_round) + r_w[0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            C_IDLE: begin
                if (i_ctl.start) begin
                    n_state = C_ROUND;
                end
            end
            C_ROUND: begin
                if (r_round == ROUND_LAST) begin
                    n_state = C_ADD;
                end
            end
            C_ADD: begin
                n_state = C_IDLE;
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_comb begin
        o_done   = (r_state == C_ADD);
        o_digest = r_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_h     <= SHA1_IV;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                C_IDLE: begin
                    if (i_ctl.start) begin
                        r_w     <= i_block;
                        r_a     <= r_h[0];
                        r_b     <= r_h[1];
                        r_c     <= r_h[2];
                        r_d     <= r_h[3];
                        r_e     <= r_h[4];
                        r_round <= '0;
                    end else if (i_ctl.reinit) begin
                        r_h <= SHA1_IV;
                    end
                end
                C_ROUND: begin
                    r_a       <= w_t;
                    r_b       <= r_a;
                    r_c       <= {r_b[1:0], r_b[31:2]};
                    r_d       <= r_c;
                    r_e       <= r_d;
                    r_w[14:0] <= r_w[15:1];
                    r_w[15]   <= w_sched_new;
                    r_round   <= (r_round == ROUND_LAST) ? '0 : r_round + 7'd1;
                end
                C_ADD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                end
                default: begin
                    r_round <= '0;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/sha1_hash_engine.sv
// sha-1 over a byte stream: bytes are absorbed while idle; every 64th byte
// then starts a compression (schedule load, 80 rounds, chain add)
// finalize: zero padding one byte per cycle, one or two compressions, then
// five digest transfers, one per cycle while m_axis_tready is high
// reset (synchronous, active low) restores the initial vector and clears the count
// depends on sha1_pkg and sha1_core
`timescale 1ns / 1ps

module sha1_hash_engine import sha1_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic [0:0]  s_axis_tuser,   // action (1 = finalize)
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_word
);

    t_state      r_state, n_state;
    t_state      r_ret;
    t_block      r_buf;
    logic [63:0] r_cnt;
    logic [6:0]  r_ppos;
    logic [2:0]  r_oidx;

    t_core_ctl   w_ctl;
    t_chain      w_digest;
    logic        w_done;
    logic        w_in_xfer;
    logic        w_out_xfer;
    logic        w_we;
    logic [5:0]  w_pos;
    logic [7:0]  w_byte;
    logic [4:0]  w_shift;
    logic [5:0]  w_cur_pos;

    assign w_cur_pos  = r_cnt[8:3];
    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer = m_axis_tvalid && m_axis_tready;
    // big-endian byte lane within the word
    assign w_shift    = {~w_pos[1:0], 3'b000};

    sha1_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_block  (r_buf),
        .o_digest (w_digest),
        .o_done   (w_done)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    if (s_axis_tuser[0]) begin
                        n_state = S_PAD;
                    end else if (w_cur_pos == BLOCK_LAST) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_PAD: begin
                if (r_ppos == PAD_BLOCK_END || r_ppos == PAD_LEN_POS) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_COMP;
            end
            S_COMP: begin
                if (w_done) begin
                    n_state = r_ret;
                end
            end
            S_OUT: begin
                if (w_out_xfer && r_oidx == WORD_LAST) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        w_ctl         = '0;
        w_we          = 1'b0;
        w_pos         = w_cur_pos;
        w_byte        = s_axis_tdata;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                w_we          = w_in_xfer;
                w_byte        = s_axis_tuser[0] ? PAD_BYTE : s_axis_tdata;
            end
            S_PAD: begin
                w_pos  = r_ppos[5:0];
                w_byte = '0;
                w_we   = (r_ppos != PAD_BLOCK_END) && (r_ppos != PAD_LEN_POS);
            end
            S_LOAD: begin
                w_ctl.start = 1'b1;
            end
            S_OUT: begin
                m_axis_tvalid = 1'b1;
                w_ctl.reinit  = w_out_xfer && (r_oidx == WORD_LAST);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign m_axis_tdata = w_digest[r_oidx];
    assign m_axis_tuser = r_oidx;
    assign m_axis_tlast = (r_oidx == WORD_LAST);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_buf[w_pos[5:2]][w_shift +: 8] <= w_byte;
        end
        if (r_state == S_PAD && r_ppos == PAD_LEN_POS) begin
            r_buf[14] <= r_cnt[63:32];
            r_buf[15] <= r_cnt[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_cnt   <= '0;
            r_ppos  <= '0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        if (s_axis_tuser[0]) begin
                            r_ppos <= {1'b0, w_cur_pos} + 7'd1;
                        end else begin
                            r_cnt <= r_cnt + 64'd8;
                            r_ret <= S_IDLE;
                        end
                    end
                end
                S_PAD: begin
                    if (r_ppos == PAD_BLOCK_END) begin
                        // padding spilled over: compress, then a fresh zero block
                        r_ppos <= '0;
                        r_ret  <= S_PAD;
                    end else if (r_ppos == PAD_LEN_POS) begin
                        r_ret <= S_OUT;
                    end else begin
                        r_ppos <= r_ppos + 7'd1;
                    end
                end
                S_OUT: begin
                    if (w_out_xfer) begin
                        if (r_oidx == WORD_LAST) begin
                            r_oidx <= '0;
                            r_cnt  <= '0;
                        end else begin
                            r_oidx <= r_oidx + 3'd1;
                        end
                    end
                end
                default: begin
                    r_oidx <= r_oidx;
                end
            endcase
        end
    end

endmodule
